@@ hdl/oofic_pkg.sv @@
// ----------------------------------------------------------------------------
// oofic_pkg
// Types, constants and fixed-point helpers for the one-over-f IIR cascade.
// ----------------------------------------------------------------------------
package oofic_pkg;

	localparam int X_W        = 40;
	localparam int C_W        = 20;
	localparam int G_W        = 24;
	localparam int IN_W       = 16;
	localparam int ACC_W      = 45;
	localparam int SUM_W      = 49;
	localparam int PROD_W     = 65;
	localparam int NUM_COEFF  = 6;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 60;
	localparam int ACTIVE_W   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 4'd7;

	localparam logic [CFG_DATA_W-1:0] COEFF_RESET  = 60'd131072;
	localparam logic [ACTIVE_W-1:0]   ACTIVE_RESET = 3'd1;
	localparam logic [G_W-1:0]        GAIN_RESET   = 24'd65536;

	localparam logic signed [SUM_W-1:0] S40_MAX = 49'sd549755813887;
	localparam logic signed [SUM_W-1:0] S40_MIN = -49'sd549755813888;

	typedef struct packed {
		logic signed [X_W-1:0] val;
		logic                  hit;
	} sat_t;

	// Round to nearest, ties up, and drop 17 fraction bits of a coefficient product.
	function automatic logic signed [ACC_W-1:0] rnd17(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		logic signed [PROD_W-1:0] s;
		t = p + 65'sh10000;
		s = t >>> 17;
		return s[ACC_W-1:0];
	endfunction

	// Round to nearest, ties up, and drop 16 fraction bits of a gain product.
	function automatic logic signed [SUM_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		logic signed [PROD_W-1:0] s;
		t = p + 65'sh8000;
		s = t >>> 16;
		return s[SUM_W-1:0];
	endfunction

	function automatic sat_t sat40(input logic signed [SUM_W-1:0] v);
		sat_t r;
		if (v > S40_MAX) begin
			r.val = S40_MAX[X_W-1:0];
			r.hit = 1'b1;
		end else if (v < S40_MIN) begin
			r.val = S40_MIN[X_W-1:0];
			r.hit = 1'b1;
		end else begin
			r.val = v[X_W-1:0];
			r.hit = 1'b0;
		end
		return r;
	endfunction

endpackage

@@ hdl/one_over_f_iir_cascade.sv @@
// ----------------------------------------------------------------------------
// one_over_f_iir_cascade
// Cascade of first-order IIR sections with output gain, built around one
// shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// in_stall stays high until the previous beat has passed every section in use and the gain step;
// each section takes three passes through the single 40x25 multiplier plus a final sum.
// The output register lets the next beat start while a result waits.
// Reset clears all section history, sets coefficients to pass-through,
// one active section and unity gain.
module one_over_f_iir_cascade #(
	parameter int SECTIONS = 6
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic signed [oofic_pkg::IN_W-1:0]          noise_in,
	input  logic                                       clear_first,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output logic signed [oofic_pkg::X_W-1:0]           noise_out,
	output logic                                       saturated,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic        [oofic_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic        [oofic_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(SECTIONS - 1);
	localparam logic [oofic_pkg::ACTIVE_W:0] SEC_CNT = 4'(SECTIONS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_FIN,
		ST_MG,
		ST_GF
	} state_t;

	state_t state_q;

	logic [oofic_pkg::CFG_DATA_W-1:0] coeff_q [oofic_pkg::NUM_COEFF];
	logic [oofic_pkg::ACTIVE_W-1:0]   active_q;
	logic [oofic_pkg::G_W-1:0]        gain_q;

	logic signed [oofic_pkg::X_W-1:0] lin_q  [SECTIONS];
	logic signed [oofic_pkg::X_W-1:0] lout_q [SECTIONS];

	logic [SEC_W-1:0]                    sec_q;
	logic signed [oofic_pkg::X_W-1:0]    x_q;
	logic signed [oofic_pkg::ACC_W-1:0]  acc_q;
	logic signed [oofic_pkg::PROD_W-1:0] prod_q;
	logic                                flag_q;
	logic                                out_valid_q;
	logic signed [oofic_pkg::X_W-1:0]    noise_out_q;
	logic                                saturated_q;

	logic [SEC_W-1:0]                    last_sec;
	logic [oofic_pkg::CFG_DATA_W-1:0]    coeff_sel;
	logic signed [oofic_pkg::X_W-1:0]    mul_a;
	logic signed [oofic_pkg::G_W:0]      mul_b;
	logic signed [oofic_pkg::PROD_W-1:0] mul_p;
	logic signed [oofic_pkg::ACC_W-1:0]  prod_rnd;
	logic signed [oofic_pkg::SUM_W-1:0]  sec_sum;
	oofic_pkg::sat_t                     sec_sat;
	oofic_pkg::sat_t                     gain_sat;
	logic                                in_beat;
	logic                                out_blocked;

	assign in_stall    = (state_q != ST_IDLE);
	assign cfg_ready   = (state_q == ST_IDLE);
	assign in_beat     = in_valid && !in_stall;
	assign out_blocked = out_valid_q && out_stall;
	assign out_valid   = out_valid_q;
	assign noise_out   = noise_out_q;
	assign saturated   = saturated_q;

	always_comb begin
		if (active_q == '0) begin
			last_sec = '0;
		end else if ({1'b0, active_q} > SEC_CNT) begin
			last_sec = LAST_SEC;
		end else begin
			last_sec = SEC_W'(active_q - 3'd1);
		end
	end

	assign coeff_sel = coeff_q[3'(sec_q)];

	always_comb begin
		unique case (state_q)
			ST_M0: begin
				mul_a = x_q;
				mul_b = {{5{coeff_sel[19]}}, coeff_sel[19:0]};
			end
			ST_M1: begin
				mul_a = lin_q[sec_q];
				mul_b = {{5{coeff_sel[39]}}, coeff_sel[39:20]};
			end
			ST_M2: begin
				mul_a = lout_q[sec_q];
				mul_b = {{5{coeff_sel[59]}}, coeff_sel[59:40]};
			end
			ST_MG: begin
				mul_a = x_q;
				mul_b = {1'b0, gain_q};
			end
			default: begin
				mul_a = x_q;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign prod_rnd = oofic_pkg::rnd17(prod_q);
	assign sec_sum  = oofic_pkg::SUM_W'(acc_q) + oofic_pkg::SUM_W'(prod_rnd);
	assign sec_sat  = oofic_pkg::sat40(sec_sum);
	assign gain_sat = oofic_pkg::sat40(oofic_pkg::rnd16(prod_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < oofic_pkg::NUM_COEFF; i++) begin
				coeff_q[i] <= oofic_pkg::COEFF_RESET;
			end
			active_q    <= oofic_pkg::ACTIVE_RESET;
			gain_q      <= oofic_pkg::GAIN_RESET;
			for (int i = 0; i < SECTIONS; i++) begin
				lin_q[i]  <= '0;
				lout_q[i] <= '0;
			end
			sec_q       <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
			x_q         <= '0;
			acc_q       <= '0;
			prod_q      <= '0;
			noise_out_q <= '0;
			saturated_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < oofic_pkg::CFG_IDX_W'(oofic_pkg::NUM_COEFF)) begin
					coeff_q[3'(cfg_index)] <= cfg_data;
				end else if (cfg_index == oofic_pkg::REG_ACTIVE) begin
					active_q <= cfg_data[oofic_pkg::ACTIVE_W-1:0];
				end else if (cfg_index == oofic_pkg::REG_GAIN) begin
					gain_q <= cfg_data[oofic_pkg::G_W-1:0];
				end
			end

			if (out_valid_q && !out_stall && (state_q != ST_GF)) begin
				out_valid_q <= 1'b0;
			end

			if (state_q != ST_GF) begin
				prod_q <= mul_p;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						x_q    <= {{20{noise_in[15]}}, noise_in, 4'b0000};
						sec_q  <= '0;
						flag_q <= 1'b0;
						if (clear_first) begin
							for (int i = 0; i < SECTIONS; i++) begin
								lin_q[i]  <= '0;
								lout_q[i] <= '0;
							end
						end
						state_q <= ST_M0;
					end
				end
				ST_M0: begin
					state_q <= ST_M1;
				end
				ST_M1: begin
					acc_q   <= prod_rnd;
					state_q <= ST_M2;
				end
				ST_M2: begin
					acc_q   <= acc_q + prod_rnd;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					lin_q[sec_q]  <= x_q;
					lout_q[sec_q] <= sec_sat.val;
					x_q           <= sec_sat.val;
					flag_q        <= flag_q | sec_sat.hit;
					if (sec_q == last_sec) begin
						state_q <= ST_MG;
					end else begin
						sec_q   <= sec_q + 1'b1;
						state_q <= ST_M0;
					end
				end
				ST_MG: begin
					state_q <= ST_GF;
				end
				ST_GF: begin
					if (!out_blocked) begin
						noise_out_q <= gain_sat.val;
						saturated_q <= flag_q | gain_sat.hit;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_M0) && (sec_q == '0))
		else $error("accepted beat did not start the first section");

	a_out_from_gain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_GF))
		else $error("result appeared without a gain step");

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GF) && out_blocked |=> (state_q == ST_GF) && $stable(noise_out_q))
		else $error("pending result overwritten");

	a_section_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (sec_q <= last_sec))
		else $error("section counter ran past the active count");

endmodule

@@ bench/tb_one_over_f_iir_cascade.sv @@
// ----------------------------------------------------------------------------
// tb_one_over_f_iir_cascade
// Self-checking bench for the cascaded IIR noise shaper. A bit-exact model of
// the sections, the gain stage and the saturation flag predicts every result,
// which is compared field by field as it leaves the block. Directed tests cover
// pass-through, clipping, section counts and history clear; random phases vary
// coefficients, gain, section count, sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_one_over_f_iir_cascade;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSECT = 6;
	localparam int LIMIT = 600000;
	localparam logic signed [79:0] TOP40 = (80'sd1 <<< 39) - 80'sd1;
	localparam logic signed [79:0] BOTTOM40 = -(80'sd1 <<< 39);

	typedef struct packed {
		logic signed [39:0] value;
		logic               clip;
	} shaped_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [oofic_pkg::IN_W-1:0] noise_in = '0;
	logic clear_first = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [oofic_pkg::X_W-1:0] noise_out;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [oofic_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [oofic_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [59:0] coeff_reg [NSECT];
	logic [2:0] active_reg;
	logic [23:0] gain_reg;
	logic signed [39:0] hist_in [NSECT];
	logic signed [39:0] hist_out [NSECT];

	shaped_t pending_outputs[$];
	int errors = 0;
	int cycles = 0;
	int results_checked = 0;
	int clipped_seen = 0;
	int samples_sent = 0;
	int clears_sent = 0;
	int stall_style = 0;
	int stall_run = 0;
	int hold_request = 0;
	int hold_left = 0;
	int gap_max = 0;
	int burst_left = 0;

	one_over_f_iir_cascade #(.SECTIONS(NSECT)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.noise_in   (noise_in),
		.clear_first(clear_first),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.noise_out  (noise_out),
		.saturated  (saturated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[one_over_f_iir_cascade] ERROR");
			$finish;
		end
	end

	function automatic logic signed [79:0] round_off(input logic signed [79:0] v, input int s);
		logic signed [79:0] t;
		t = v + (80'sd1 <<< (s - 1));
		return t >>> s;
	endfunction

	function automatic logic signed [79:0] clamp40(input logic signed [79:0] v, inout logic hit);
		if (v > TOP40) begin
			hit = 1'b1;
			return TOP40;
		end
		if (v < BOTTOM40) begin
			hit = 1'b1;
			return BOTTOM40;
		end
		return v;
	endfunction

	function automatic shaped_t shape_sample(input logic signed [15:0] noise, input logic clear);
		logic signed [79:0] x, c0, c1, d0, acc, gain;
		logic hit;
		int n;
		shaped_t r;
		hit = 1'b0;
		x = 80'(noise);
		x = x <<< 4;
		if (clear) begin
			for (int k = 0; k < NSECT; k++) begin
				hist_in[k] = '0;
				hist_out[k] = '0;
			end
		end
		n = int'(active_reg);
		if (n < 1) n = 1;
		if (n > NSECT) n = NSECT;
		for (int k = 0; k < n; k++) begin
			c0 = 80'($signed(coeff_reg[k][19:0]));
			c1 = 80'($signed(coeff_reg[k][39:20]));
			d0 = 80'($signed(coeff_reg[k][59:40]));
			acc = round_off(c0 * x, 17) + round_off(c1 * 80'(hist_in[k]), 17)
				+ round_off(d0 * 80'(hist_out[k]), 17);
			acc = clamp40(acc, hit);
			hist_in[k] = x[39:0];
			hist_out[k] = acc[39:0];
			x = acc;
		end
		gain = {56'd0, gain_reg};
		x = clamp40(round_off(x * gain, 16), hit);
		r.value = x[39:0];
		r.clip = hit;
		return r;
	endfunction

	function automatic void add_expected(input shaped_t r);
		pending_outputs.insert(pending_outputs.size(), r);
	endfunction

	always @(posedge clk) begin
		shaped_t want;
		if (out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				$error("unexpected result beat: noise_out %0d", noise_out);
				errors++;
			end else begin
				want = pending_outputs.pop_front();
				if (noise_out !== want.value) begin
					$error("noise_out: expected %0d, got %0d", want.value, noise_out);
					errors++;
				end
				if (saturated !== want.clip) begin
					$error("saturated: expected %0b, got %0b", want.clip, saturated);
					errors++;
				end
				results_checked++;
				if (want.clip) clipped_seen++;
			end
		end
		if (in_valid && !in_stall)
			add_expected(shape_sample(noise_in, clear_first));
	end

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
			out_stall <= 1'b1;
		end else begin
			case (stall_style)
				1: out_stall <= ($urandom_range(9, 0) < 3);
				2: begin
					if ($urandom_range(7, 0) == 0) begin
						stall_run = $urandom_range(6, 1);
						out_stall <= 1'b1;
					end else begin
						out_stall <= 1'b0;
					end
				end
				default: out_stall <= 1'b0;
			endcase
		end
	end

	task automatic write_reg(input logic [3:0] index, input logic [59:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (index < NSECT)
			coeff_reg[3'(index)] = data;
		else if (index == oofic_pkg::REG_ACTIVE)
			active_reg = data[2:0];
		else if (index == oofic_pkg::REG_GAIN)
			gain_reg = data[23:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sample(input logic signed [15:0] noise, input logic clear);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		noise_in <= noise;
		clear_first <= clear;
		do @(posedge clk); while (in_stall);
		samples_sent++;
		if (clear) clears_sent++;
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				gap = $urandom_range(gap_max, 1);
				burst_left = $urandom_range(12, 1);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic signed [15:0] random_noise();
		case ($urandom_range(9, 0))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [59:0] pink_coeffs();
		logic [19:0] c0, c1, d0;
		c0 = 20'($urandom_range(32'h3FFFF, 0) - 32'h20000);
		c1 = 20'($urandom_range(32'h3FFFF, 0) - 32'h20000);
		d0 = 20'($urandom_range(32'h1FFFF, 0));
		return {d0, c1, c0};
	endfunction

	task automatic test_passthrough();
		gap_max = 0;
		stall_style = 0;
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b1);
		send_sample(16'sh0001, 1'b0);
		send_sample(-16'sh0001, 1'b0);
		settle();
		write_reg(oofic_pkg::REG_GAIN, 60'hFFFFFF);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b1);
		settle();
	endtask

	task automatic test_clipping();
		stall_style = 1;
		for (int k = 0; k < NSECT; k++)
			write_reg(4'(k), {20'h7FFFF, 20'h80000, 20'h7FFFF});
		write_reg(oofic_pkg::REG_ACTIVE, 60'd6);
		repeat (5) send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh8000, 1'b1);
		repeat (5) send_sample(16'sh8000, 1'b0);
		settle();
	endtask

	task automatic test_section_count();
		stall_style = 2;
		for (int k = 0; k < NSECT; k++)
			write_reg(4'(k), pink_coeffs());
		write_reg(oofic_pkg::REG_GAIN, 60'hABC_0000_0001_0000);
		write_reg(oofic_pkg::REG_ACTIVE, 60'd0);
		send_sample(random_noise(), 1'b1);
		send_sample(random_noise(), 1'b0);
		settle();
		write_reg(oofic_pkg::REG_ACTIVE, 60'd7);
		send_sample(random_noise(), 1'b0);
		send_sample(random_noise(), 1'b0);
		settle();
		write_reg(oofic_pkg::REG_ACTIVE, 60'hFFF_FFFF_FFFF_FFFB);
		write_reg(4'($urandom_range(15, oofic_pkg::REG_GAIN + 1)), 60'({$urandom, $urandom}));
		send_sample(random_noise(), 1'b0);
		send_sample(random_noise(), 1'b0);
		settle();
	endtask

	task automatic test_backpressure();
		stall_style = 0;
		gap_max = 0;
		hold_request = 400;
		repeat (60) send_sample(random_noise(), $urandom_range(19, 0) == 0);
		settle();
	endtask

	task automatic test_random_settings();
		logic [59:0] data;
		for (int p = 0; p < 7; p++) begin
			for (int k = 0; k < NSECT; k++) begin
				if (p % 3 == 0)
					data = 60'({$urandom, $urandom});
				else
					data = pink_coeffs();
				write_reg(4'(k), data);
			end
			data = 60'({$urandom, $urandom});
			data[2:0] = (p == 0) ? 3'd6 : 3'($urandom_range(7, 0));
			write_reg(oofic_pkg::REG_ACTIVE, data);
			data = 60'({$urandom, $urandom});
			if (p == 1)
				data[23:0] = 24'd0;
			else if (p == 2)
				data[23:0] = 24'hFFFFFF;
			write_reg(oofic_pkg::REG_GAIN, data);
			if (p == 4)
				write_reg(4'($urandom_range(15, oofic_pkg::REG_GAIN + 1)),
					60'({$urandom, $urandom}));
			case (p % 3)
				0: gap_max = 30;
				1: gap_max = 4;
				default: gap_max = 0;
			endcase
			stall_style = p % 3;
			burst_left = 0;
			repeat (230) send_sample(random_noise(), $urandom_range(19, 0) == 0);
			settle();
		end
	endtask

	initial begin
		for (int k = 0; k < NSECT; k++) begin
			coeff_reg[k] = oofic_pkg::COEFF_RESET;
			hist_in[k] = '0;
			hist_out[k] = '0;
		end
		active_reg = oofic_pkg::ACTIVE_RESET;
		gain_reg = oofic_pkg::GAIN_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_passthrough();
		test_clipping();
		test_section_count();
		test_backpressure();
		test_random_settings();
		repeat (20) @(posedge clk);
		$display("Sent %0d samples (%0d with history clear), checked %0d results, %0d clipped.",
			samples_sent, clears_sent, results_checked, clipped_seen);
		$display("Covered reset pass-through, clipping, section counts, backpressure, random setups.");
		if (errors == 0 && pending_outputs.size() == 0)
			$display("[one_over_f_iir_cascade] OK");
		else
			$display("[one_over_f_iir_cascade] ERROR");
		$finish;
	end

endmodule
